@@ hdl/bba_pkg.sv @@
// shared types and constants of the bitmap block allocator
// no dependencies; used by bitmap_block_allocator, bba_checker and tb
`default_nettype none

package bba_pkg;

    // default map geometry
    localparam int MAP_WORDS_DEF = 512;
    localparam int WORD_BITS_DEF = 32;

    // field widths
    localparam int BLOCK_W   = 14;
    localparam int COUNT_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FS_VALID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_BLOCKS = 2'd1;

    // request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status codes
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    localparam logic [COUNT_W-1:0] NUM_BLOCKS_RST = 15'd16384;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } bba_state_t;

endpackage

`default_nettype wire

@@ hdl/bitmap_block_allocator.sv @@
// first-fit free-block bitmap allocator, top level
// depends on bba_pkg
`default_nettype none

// The free map (a 1 bit marks a free block) lives in one synchronous memory of
// MAP_WORDS words of WORD_BITS bits, read one word per cycle through a registered
// read port. After reset the block runs a clearing pass that writes every word
// to all ones; no request is taken during it, while configuration writes are
// taken at any time. An allocate request walks the map from word 0, one word
// read per cycle, and stops at the first word with a free bit below the block
// limit, or fails after the last word below the limit. A free request steps the
// word counter up to the word that holds the block, reads it once and writes it
// back with the bit set if it was not already free. Requests that fail up front
// (filesystem not valid, free out of range, block limit of zero) go straight to
// the result state. One request is worked on at a time; the next one is taken
// while the previous result still waits in the output register.
module bitmap_block_allocator #(
    parameter int MAP_WORDS = bba_pkg::MAP_WORDS_DEF,
    parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bba_pkg::COUNT_W-1:0]    cfg_data,
    // request stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [bba_pkg::TDATA_W-1:0]    s_axis_tdata,  // [13:0] block_in, rest zero
    input  wire logic [0:0]                     s_axis_tuser,  // [0] action
    // result stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [bba_pkg::TDATA_W-1:0]         m_axis_tdata,  // [13:0] block_out, rest zero
    output logic [0:0]                          m_axis_tuser   // [0] status
);

    localparam int AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIW  = $clog2(WORD_BITS);
    localparam int LW   = bba_pkg::COUNT_W;      // block limit width
    localparam int BSW  = LW + 1;                // word base, may run past the limit
    localparam int BW   = bba_pkg::BLOCK_W;
    localparam int CAP  = MAP_WORDS * WORD_BITS;
    localparam int LMAX = (1 << LW) - 1;
    // map capacity, saturated to what the block count can express
    localparam logic [LW-1:0] CAP_SAT = (CAP > LMAX) ? LW'(LMAX) : LW'(CAP);
    localparam logic [BSW-1:0] WB_EXT = BSW'(WORD_BITS);
    localparam logic [AW-1:0]  LAST_WORD = AW'(MAP_WORDS - 1);

    // configuration registers
    logic            fs_valid_reg;
    logic [LW-1:0]   num_blocks_reg;

    // free map memory
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] mem_q_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [WORD_BITS-1:0] mem_wd;

    // control
    bba_pkg::bba_state_t state_reg, state_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic            iss_on_reg, iss_on_next;
    logic [AW-1:0]   iss_addr_reg, iss_addr_next;
    logic [BSW-1:0]  iss_base_reg, iss_base_next;
    logic            evl_vld_reg, evl_vld_next;
    logic            out_full_reg, out_full_next;

    // request payload
    logic            act_reg, act_next;
    logic [BW-1:0]   blk_reg, blk_next;
    logic [LW-1:0]   lim_reg, lim_next;
    logic [AW-1:0]   evl_addr_reg, evl_addr_next;
    logic [BSW-1:0]  evl_base_reg, evl_base_next;
    logic            res_status_reg, res_status_next;
    logic [BW-1:0]   res_block_reg, res_block_next;
    logic            out_status_reg, out_status_next;
    logic [BW-1:0]   out_block_reg, out_block_next;

    // evaluation of the word just read
    logic [LW-1:0]        limit_c;
    logic [BSW-1:0]       blk_ext;
    logic [BSW-1:0]       lim_ext;
    logic [BSW-1:0]       room;
    logic [WORD_BITS-1:0] cand;
    logic                 found;
    logic [BIW-1:0]       found_idx;
    logic [BIW-1:0]       free_bit;
    logic [BSW-1:0]       free_off;
    logic [BSW-1:0]       alloc_n;
    logic                 iss_go;
    logic                 last_word;

    assign limit_c = (num_blocks_reg < CAP_SAT) ? num_blocks_reg : CAP_SAT;
    assign blk_ext = BSW'(blk_reg);
    assign lim_ext = BSW'(lim_reg);

    // blocks of this word still below the limit
    assign room = lim_ext - evl_base_reg;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            cand[i] = mem_q_reg[i] & (BSW'(i) < room);
        end
    end

    // lowest free bit
    always_comb
    begin
        found_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found_idx = BIW'(i);
            end
        end
    end

    assign found     = |cand;
    assign alloc_n   = evl_base_reg + BSW'(found_idx);
    assign free_off  = blk_ext - evl_base_reg;
    assign free_bit  = free_off[BIW-1:0];
    assign last_word = (evl_base_reg + WB_EXT) >= lim_ext;

    // configuration port, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_valid_reg   <= 1'b0;
            num_blocks_reg <= bba_pkg::NUM_BLOCKS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bba_pkg::REG_FS_VALID:   fs_valid_reg   <= cfg_data[0];
                bba_pkg::REG_NUM_BLOCKS: num_blocks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // map memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= map_mem[iss_addr_reg];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bba_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            iss_on_reg   <= 1'b0;
            iss_addr_reg <= '0;
            iss_base_reg <= '0;
            evl_vld_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            iss_on_reg   <= iss_on_next;
            iss_addr_reg <= iss_addr_next;
            iss_base_reg <= iss_base_next;
            evl_vld_reg  <= evl_vld_next;
            out_full_reg <= out_full_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        blk_reg        <= blk_next;
        lim_reg        <= lim_next;
        evl_addr_reg   <= evl_addr_next;
        evl_base_reg   <= evl_base_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        out_status_reg <= out_status_next;
        out_block_reg  <= out_block_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        iss_on_next     = iss_on_reg;
        iss_addr_next   = iss_addr_reg;
        iss_base_next   = iss_base_reg;
        evl_vld_next    = 1'b0;
        evl_addr_next   = iss_addr_reg;
        evl_base_next   = iss_base_reg;
        out_full_next   = out_full_reg;
        act_next        = act_reg;
        blk_next        = blk_reg;
        lim_next        = lim_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        out_status_next = out_status_reg;
        out_block_next  = out_block_reg;
        mem_we          = 1'b0;
        mem_wa          = clr_addr_reg;
        mem_wd          = '1;
        iss_go          = 1'b0;
        s_axis_tready   = 1'b0;

        // result taken downstream
        if (out_full_reg && m_axis_tready)
        begin
            out_full_next = 1'b0;
        end

        case (state_reg)
            bba_pkg::ST_CLEAR:
            begin
                // write every word to all free
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end

            bba_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    act_next        = s_axis_tuser[0];
                    blk_next        = s_axis_tdata[BW-1:0];
                    lim_next        = limit_c;
                    iss_on_next     = 1'b1;
                    iss_addr_next   = '0;
                    iss_base_next   = '0;
                    res_status_next = bba_pkg::STAT_FAIL;
                    res_block_next  = '0;
                    if (!fs_valid_reg
                        || (s_axis_tuser[0] == bba_pkg::ACT_FREE
                            && LW'(s_axis_tdata[BW-1:0]) >= limit_c)
                        || (s_axis_tuser[0] == bba_pkg::ACT_ALLOC && limit_c == '0))
                    begin
                        state_next = bba_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = bba_pkg::ST_SCAN;
                    end
                end
            end

            bba_pkg::ST_SCAN:
            begin
                // read side: walk the word counter
                if (iss_on_reg)
                begin
                    if (act_reg == bba_pkg::ACT_ALLOC)
                    begin
                        if (iss_base_reg < lim_ext)
                        begin
                            iss_go        = 1'b1;
                            iss_addr_next = iss_addr_reg + AW'(1);
                            iss_base_next = iss_base_reg + WB_EXT;
                        end
                        else
                        begin
                            iss_on_next = 1'b0;
                        end
                    end
                    else if (blk_ext < iss_base_reg + WB_EXT)
                    begin
                        // word holding the block: read it once
                        iss_go      = 1'b1;
                        iss_on_next = 1'b0;
                    end
                    else
                    begin
                        iss_addr_next = iss_addr_reg + AW'(1);
                        iss_base_next = iss_base_reg + WB_EXT;
                    end
                end
                evl_vld_next = iss_go;

                // evaluate side: word read in the previous cycle
                if (evl_vld_reg)
                begin
                    mem_wa = evl_addr_reg;
                    mem_wd = mem_q_reg;
                    if (act_reg == bba_pkg::ACT_ALLOC)
                    begin
                        if (found)
                        begin
                            mem_wd[found_idx] = 1'b0;
                            mem_we            = 1'b1;
                            res_status_next   = bba_pkg::STAT_OK;
                            res_block_next    = alloc_n[BW-1:0];
                            state_next        = bba_pkg::ST_DONE;
                        end
                        else if (last_word)
                        begin
                            state_next = bba_pkg::ST_DONE;
                        end
                    end
                    else
                    begin
                        if (!mem_q_reg[free_bit])
                        begin
                            mem_wd[free_bit] = 1'b1;
                            mem_we           = 1'b1;
                            res_status_next  = bba_pkg::STAT_OK;
                        end
                        state_next = bba_pkg::ST_DONE;
                    end
                    if (state_next == bba_pkg::ST_DONE)
                    begin
                        iss_on_next  = 1'b0;
                        evl_vld_next = 1'b0;
                    end
                end
            end

            bba_pkg::ST_DONE:
            begin
                // hand the result to the output register once it is free
                if (!out_full_reg || m_axis_tready)
                begin
                    out_full_next   = 1'b1;
                    out_status_next = res_status_reg;
                    out_block_next  = res_block_reg;
                    state_next      = bba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid   = out_full_reg;
    assign m_axis_tdata    = bba_pkg::TDATA_W'(out_block_reg);
    assign m_axis_tuser[0] = out_status_reg;

endmodule

`default_nettype wire

@@ tb/bba_checker.sv @@
// result checker for the bitmap block allocator: keeps its own free map and registers,
// predicts every result from the accepted requests and compares in order
// depends on bba_pkg
`timescale 1ns / 100ps
`default_nettype none

module bba_checker
    import bba_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COUNT_W-1:0]    cfg_data,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [TDATA_W-1:0]    s_axis_tdata,   // [13:0] block_in, rest zero
    input  wire logic [0:0]            s_axis_tuser,   // [0] action
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [TDATA_W-1:0]    m_axis_tdata,   // [13:0] block_out, rest zero
    input  wire logic [0:0]            m_axis_tuser,   // [0] status
    output int                         mismatch_count,
    output int                         results_pending
);

    localparam int MAP_WORDS = MAP_WORDS_DEF;
    localparam int WORD_BITS = WORD_BITS_DEF;
    localparam int CAPACITY  = MAP_WORDS * WORD_BITS;

    typedef struct packed {
        logic               status;
        logic [BLOCK_W-1:0] block;
    } alloc_result_t;

    logic [WORD_BITS-1:0] free_words [MAP_WORDS];
    logic                 fs_valid_q;
    logic [COUNT_W-1:0]   num_blocks_q;
    alloc_result_t        expected_results [$];
    alloc_result_t        got;
    alloc_result_t        want;
    int                   w;

    // first fit over the map, or a free of one block; updates the map copy
    function automatic alloc_result_t predict_allocation(input logic act,
                                                         input logic [BLOCK_W-1:0] blk);
        alloc_result_t r;
        int unsigned   lim;
        int unsigned   n;
        bit            found;
        r.status = STAT_FAIL;
        r.block  = '0;
        found    = 1'b0;
        lim = (num_blocks_q > CAPACITY) ? CAPACITY : num_blocks_q;
        if (fs_valid_q)
        begin
            if (act == ACT_ALLOC)
            begin
                for (n = 0; n < lim && !found; n++)
                begin
                    if (free_words[n / WORD_BITS][n % WORD_BITS])
                    begin
                        free_words[n / WORD_BITS][n % WORD_BITS] = 1'b0;
                        r.status = STAT_OK;
                        r.block  = BLOCK_W'(n);
                        found    = 1'b1;
                    end
                end
            end
            else if (blk < lim && !free_words[blk / WORD_BITS][blk % WORD_BITS])
            begin
                free_words[blk / WORD_BITS][blk % WORD_BITS] = 1'b1;
                r.status = STAT_OK;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (w = 0; w < MAP_WORDS; w++)
                free_words[w] = '1;
            fs_valid_q      = 1'b0;
            num_blocks_q    = NUM_BLOCKS_RST;
            expected_results.delete();
            mismatch_count  = 0;
            results_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FS_VALID)
                    fs_valid_q = cfg_data[0];
                else if (cfg_index == REG_NUM_BLOCKS)
                    num_blocks_q = cfg_data;
            end
            // results first: a request taken at this edge cannot have its result yet
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tuser[0];
                got.block  = m_axis_tdata[BLOCK_W-1:0];
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, status %0d block %0d", $time,
                             got.status, got.block);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        mismatch_count++;
                        $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                                 want.status, got.status);
                    end
                    if (got.block !== want.block)
                    begin
                        mismatch_count++;
                        $display("%0t: block_out mismatch, expected %0d, actual %0d", $time,
                                 want.block, got.block);
                    end
                    if (m_axis_tdata[TDATA_W-1:BLOCK_W] !== '0)
                    begin
                        mismatch_count++;
                        $display("%0t: tdata padding mismatch, expected 0, actual %0h", $time,
                                 m_axis_tdata[TDATA_W-1:BLOCK_W]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_allocation(s_axis_tuser[0],
                                                              s_axis_tdata[BLOCK_W-1:0]));
            results_pending = expected_results.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// testbench top for the bitmap block allocator: clock, reset, request and
// configuration stimulus, result back-pressure and the final verdict
// depends on bba_pkg, bba_checker and bitmap_block_allocator
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import bba_pkg::*;

    // cycle limit, several times the slowest plausible run including the clearing pass
    localparam int CYCLE_LIMIT = 2000000;
    // length of the long receiver hold-off, long enough to back the block up
    localparam int HOLD_OFF_CYCLES = 400;

    // indexes with no register behind them, written once to show they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0]   cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;   // [13:0] block_in, rest zero
    logic [0:0]           s_axis_tuser = '0;   // [0] action
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;        // [13:0] block_out, rest zero
    logic [0:0]           m_axis_tuser;        // [0] status

    int check_failures;
    int results_pending;

    // idling percentages for the current phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // bumped by the stimulus to ask the receiver for one long hold-off
    int hold_off_reqs  = 0;
    int cycle_count    = 0;

    bitmap_block_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bba_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatch_count  (check_failures),
        .results_pending (results_pending)
    );

    // 20 ns clock
    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // watchdog: a hung handshake ends the run as a failure
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stalls, or one long hold-off when asked so that the
    // block fills its output register, stops taking requests and backs up the sender
    initial
    begin
        int hold_seen;
        int k;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_reqs != hold_seen)
            begin
                hold_seen = hold_off_reqs;
                m_axis_tready <= 1'b0;
                for (k = 1; k < HOLD_OFF_CYCLES; k++)
                    @(negedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // offer one request, with a random gap first; returns at the accepting edge
    // and leaves tvalid alone, the next negedge decides whether it stays up
    task automatic send_request(input logic act, input logic [BLOCK_W-1:0] blk);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(blk);
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // register write, only ever done with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one random phase: settings, idling pattern, then bursts that lean towards
    // allocation or towards freeing so the map both fills up and empties again
    task automatic run_phase(input idle_mode_t mode, input logic fsv,
                             input logic [COUNT_W-1:0] nb, input int count,
                             input bit long_hold);
        int lim;
        int span;
        int alloc_pct;
        int i;
        logic act;
        logic [BLOCK_W-1:0] blk;
        // upper data bits are junk, only bit 0 counts for fs_valid
        write_reg(REG_FS_VALID, {(COUNT_W-1)'($urandom), fsv});
        write_reg(REG_NUM_BLOCKS, nb);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 56; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            IDLE_BOTH:     begin send_idle_pct = 21; recv_stall_pct = 21; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
        if (long_hold)
            hold_off_reqs++;
        lim  = (nb > 16384) ? 16384 : nb;
        // allocated blocks sit low in the map, so most frees aim there
        span = (lim < 64) ? lim + 2 : 63;
        for (i = 0; i < count; i++)
        begin
            alloc_pct = ((i / 16) % 2 == 0) ? 75 : 25;
            act = ($urandom_range(0, 99) < alloc_pct) ? ACT_ALLOC : ACT_FREE;
            if ($urandom_range(0, 99) < 25)
                blk = BLOCK_W'($urandom);
            else
                blk = BLOCK_W'($urandom_range(0, span));
            send_request(act, blk);
            // sender waits for every result once in the middle of the phase
            if (long_hold && i == count / 2)
                drain_results();
        end
        drain_results();
    endtask

    initial
    begin
        // reset held low, then released on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // filesystem not valid out of reset: everything fails
        send_request(ACT_ALLOC, 14'd0);
        send_request(ACT_FREE, 14'd5);

        write_reg(REG_FS_VALID, 15'h7FFF);
        write_reg(REG_SPARE_2, 15'h0000);
        write_reg(REG_SPARE_3, 15'h7FFF);
        // full map at the reset block count
        send_request(ACT_ALLOC, 14'h3FFF);
        send_request(ACT_ALLOC, 14'd0);
        send_request(ACT_FREE, 14'd0);
        // double free, also at the top block number
        send_request(ACT_FREE, 14'd0);
        send_request(ACT_FREE, 14'h3FFF);
        send_request(ACT_ALLOC, 14'd0);

        // block limit of zero: no allocate, every free out of range
        write_reg(REG_NUM_BLOCKS, 15'd0);
        send_request(ACT_ALLOC, 14'd0);
        send_request(ACT_FREE, 14'd0);

        // tiny limit: fill it, fail when full, free out of range, free and reuse
        write_reg(REG_NUM_BLOCKS, 15'd3);
        send_request(ACT_ALLOC, 14'd0);
        send_request(ACT_ALLOC, 14'd0);
        send_request(ACT_FREE, 14'd3);
        send_request(ACT_FREE, 14'd2);
        send_request(ACT_ALLOC, 14'd0);

        // block count above capacity saturates
        write_reg(REG_NUM_BLOCKS, 15'h7FFF);
        send_request(ACT_ALLOC, 14'd0);
        send_request(ACT_FREE, 14'h3FFF);
        send_request(ACT_FREE, 14'd3);
        write_reg(REG_NUM_BLOCKS, 15'd16384);
        send_request(ACT_ALLOC, 14'd0);

        // filesystem dropped again, bit 0 clear with upper bits set
        write_reg(REG_FS_VALID, 15'h7FFE);
        send_request(ACT_ALLOC, 14'd0);
        send_request(ACT_FREE, 14'd1);

        run_phase(IDLE_NONE,     1'b1, 15'd24,    130, 1'b0);
        run_phase(IDLE_SENDER,   1'b1, 15'd40,    130, 1'b0);
        run_phase(IDLE_RECEIVER, 1'b1, 15'd16384, 110, 1'b1);
        run_phase(IDLE_BOTH,     1'b1, 15'd9,     130, 1'b0);
        run_phase(IDLE_NONE,     1'b1, 15'h7FFF,  80,  1'b0);
        run_phase(IDLE_SENDER,   1'b1, COUNT_W'($urandom_range(1, 64)), 130, 1'b0);
        run_phase(IDLE_RECEIVER, 1'b0, 15'd30,    60,  1'b0);
        run_phase(IDLE_BOTH,     1'b1, 15'd1,     100, 1'b0);
        run_phase(IDLE_RECEIVER, 1'b1, COUNT_W'($urandom_range(1, 64)), 100, 1'b0);
        run_phase(IDLE_NONE,     1'b1, 15'd0,     40,  1'b0);
        run_phase(IDLE_BOTH,     1'b1, COUNT_W'($urandom_range(0, 32767)), 60, 1'b0);

        drain_results();
        repeat (10) @(negedge clk);
        if (check_failures == 0 && results_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/bba_pkg.sv
hdl/bitmap_block_allocator.sv
tb/bba_checker.sv
tb/tb.sv
